// File: rtl/voxel_grid_sum_downsample_macros.svh
// Assertion macros for the voxel grid downsampler checker.
`ifndef VOXEL_GRID_SUM_DOWNSAMPLE_MACROS_SVH
`define VOXEL_GRID_SUM_DOWNSAMPLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define VGSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgsd check failed");

// next-cycle implication, disabled during reset
`define VGSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgsd check failed");

// next-cycle implication that also holds through reset
`define VGSD_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vgsd check failed");

`endif

// File: rtl/vgsd_pkg.sv
// Package: field widths, opcodes, status codes and controller states.
`timescale 1ns / 1ps
package vgsd_pkg;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 15;
  localparam int VALUE_W  = 32;
  localparam int SIDE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int SHIFT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_HALVE   = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTORE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SIDE1 = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_HALVE,
    ST_HDRAIN,
    ST_HCLEAR,
    ST_COPY,
    ST_CDRAIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/vgsd_in_if.sv
// Interface: input channel carrying one command word.
`timescale 1ns / 1ps
interface vgsd_in_if;
  import vgsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  cell_index;
  logic [VALUE_W-1:0]  cell_value;

  modport source (output valid, output opcode, output cell_index, output cell_value,
                  input ready);
  modport sink   (input valid, input opcode, input cell_index, input cell_value,
                  output ready);
endinterface

// File: rtl/vgsd_out_if.sv
// Interface: result channel carrying one response word.
`timescale 1ns / 1ps
interface vgsd_out_if;
  import vgsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic [VALUE_W-1:0]  grid_max;
  logic [SIDE_W-1:0]   side_log2;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_value, output grid_max, output side_log2,
                  output status, input ready);
  modport sink   (input valid, input read_value, input grid_max, input side_log2,
                  input status, output ready);
endinterface

// File: rtl/voxel_grid_sum_downsample.sv
// Top level: voxel count grid with in-place 2x2x2 saturating sum downsampling.
// A halve reads the working memory eight times per new cell, writes each new cell back
// and then zeroes the 7*n^3 cells beyond the new grid, n being the new side; a restore
// copies the original grid back; the one working memory port pair is shared by all of these.
// A word is taken while the previous response waits in the output register.
// Sync reset clears control and maxima; the grid memories are not cleared.
`timescale 1ns / 1ps
module voxel_grid_sum_downsample #(
  parameter int MAX_SIDE_LOG2 = 5,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  vgsd_in_if.sink                      in_ch,
  vgsd_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [vgsd_pkg::SIDE_W-1:0]  cfg_wdata
);
  import vgsd_pkg::*;

  localparam int AW    = 3 * MAX_SIDE_LOG2;
  localparam int CELLS = 1 << AW;
  localparam int CW    = COUNT_WIDTH;
  localparam int MW    = MAX_SIDE_LOG2;

  state_t state_r, state_nxt;

  // memories
  logic [CW-1:0] work_mem_r [CELLS];
  logic [CW-1:0] orig_mem_r [CELLS];
  logic [CW-1:0] work_q_r;
  logic [CW-1:0] orig_q_r;

  logic          wm_we, wm_re, om_we;
  logic [AW-1:0] wm_waddr, wm_raddr;
  logic [CW-1:0] wm_wdata;

  // architectural state
  logic [SIDE_W-1:0] full_r;
  logic [SIDE_W-1:0] cur_side_r;
  logic [CW-1:0]     orig_max_r;
  logic [CW-1:0]     cur_max_r;

  // result
  logic              out_valid_r;
  logic [CW-1:0]     out_rd_r, res_rd_r;
  logic [CW-1:0]     out_max_r;
  logic [SIDE_W-1:0] out_side_r;
  status_t           out_status_r, res_status_r;

  // halve walk
  logic [MW-1:0] hx_r, hy_r, hz_r;
  logic [2:0]    hd_r;
  logic [AW-1:0] hj_r;
  logic          hrd_v_r, hrd_first_r, hrd_last_r;
  logic [AW-1:0] hrd_j_r;
  logic [CW-1:0] acc_r;
  logic          sum_v_r;
  logic [CW-1:0] sum_r;
  logic [AW-1:0] sum_j_r;
  logic [AW-1:0] clr_r;

  // restore copy
  logic [AW-1:0] cp_cnt_r;
  logic          cp_v_r;
  logic [AW-1:0] cp_a_r;

  // decode
  logic              accept, out_load;
  opcode_t           in_op;
  logic [CW-1:0]     in_val;
  logic [AW-1:0]     in_addr;
  logic [SIDE_W-1:0] full_eff, cfg_eff, nl;
  logic [SHIFT_W-1:0] full_sh, cur_sh;
  logic              idx_in_full, idx_in_cur;
  logic [MW-1:0]     nmask;
  logic [AW-1:0]     h_addr, clr_start, clr_last, cp_last;
  logic              h_issue_last, h_block_end, clr_done, cp_done;
  logic [CW:0]       sum_wide;
  logic [CW-1:0]     sum_sat, acc_in;

  assign in_op   = opcode_t'(in_ch.opcode);
  assign in_val  = CW'(in_ch.cell_value);
  assign in_addr = AW'(in_ch.cell_index);

  assign full_eff = (int'(full_r) > MAX_SIDE_LOG2) ? SIDE_W'(MAX_SIDE_LOG2) : full_r;
  assign cfg_eff  = (int'(cfg_wdata) > MAX_SIDE_LOG2) ? SIDE_W'(MAX_SIDE_LOG2) : cfg_wdata;
  assign nl       = cur_side_r - SIDE_W'(1);

  assign full_sh     = SHIFT_W'(3 * int'(full_eff));
  assign cur_sh      = SHIFT_W'(3 * int'(cur_side_r));
  assign idx_in_full = (in_ch.cell_index >> full_sh) == '0;
  assign idx_in_cur  = (in_ch.cell_index >> cur_sh) == '0;

  // halve source address: (2z+dz)*on^2 + (2y+dy)*on + (2x+dx), on = 2^side
  assign nmask  = MW'((1 << nl) - 1);
  assign h_addr = AW'({hx_r, hd_r[0]})
                | (AW'({hy_r, hd_r[1]}) << cur_side_r)
                | (AW'({hz_r, hd_r[2]}) << {cur_side_r, 1'b0});

  assign h_block_end  = (hd_r == 3'd7);
  assign h_issue_last = h_block_end && (hx_r == nmask) && (hy_r == nmask) && (hz_r == nmask);
  assign clr_start    = AW'(1 << (3 * int'(nl)));
  assign clr_last     = AW'((1 << (3 * int'(cur_side_r))) - 1);
  assign clr_done     = (clr_r == clr_last);
  assign cp_last      = AW'((1 << (3 * int'(full_eff))) - 1);
  assign cp_done      = (cp_cnt_r == cp_last);

  assign sum_wide = {1'b0, acc_r} + {1'b0, work_q_r};
  assign sum_sat  = sum_wide[CW] ? '1 : sum_wide[CW-1:0];
  assign acc_in   = hrd_first_r ? work_q_r : sum_sat;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_READ:    state_nxt = idx_in_cur ? ST_READ : ST_DONE;
            OP_HALVE:   state_nxt = (cur_side_r == '0) ? ST_DONE : ST_HALVE;
            OP_RESTORE: state_nxt = ST_COPY;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_DONE;
      ST_HALVE:  if (h_issue_last) state_nxt = ST_HDRAIN;
      ST_HDRAIN: if (!hrd_v_r && !sum_v_r) state_nxt = ST_HCLEAR;
      ST_HCLEAR: if (clr_done) state_nxt = ST_DONE;
      ST_COPY:   if (cp_done) state_nxt = ST_CDRAIN;
      ST_CDRAIN: state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs and memory port muxing
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    accept      = in_ch.valid && (state_r == ST_IDLE);
    out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

    om_we    = accept && (in_op == OP_LOAD) && idx_in_full;
    wm_re    = (accept && (in_op == OP_READ) && idx_in_cur) || (state_r == ST_HALVE);
    wm_raddr = (state_r == ST_HALVE) ? h_addr : in_addr;

    wm_we    = 1'b0;
    wm_waddr = in_addr;
    wm_wdata = in_val;
    if (om_we) begin
      wm_we = 1'b1;
    end else if (sum_v_r) begin
      wm_we    = 1'b1;
      wm_waddr = sum_j_r;
      wm_wdata = sum_r;
    end else if (state_r == ST_HCLEAR) begin
      wm_we    = 1'b1;
      wm_waddr = clr_r;
      wm_wdata = '0;
    end else if (cp_v_r) begin
      wm_we    = 1'b1;
      wm_waddr = cp_a_r;
      wm_wdata = orig_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wm_we) work_mem_r[wm_waddr] <= wm_wdata;
    if (wm_re) work_q_r <= work_mem_r[wm_raddr];
  end

  always_ff @(posedge clk) begin
    if (om_we) orig_mem_r[in_addr] <= in_val;
    if (state_r == ST_COPY) orig_q_r <= orig_mem_r[cp_cnt_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      full_r      <= SIDE_W'(5);
      cur_side_r  <= (MAX_SIDE_LOG2 < 5) ? SIDE_W'(MAX_SIDE_LOG2) : SIDE_W'(5);
      orig_max_r  <= '0;
      cur_max_r   <= '0;
      hrd_v_r     <= 1'b0;
      sum_v_r     <= 1'b0;
      cp_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hrd_v_r <= (state_r == ST_HALVE);
      sum_v_r <= hrd_v_r && hrd_last_r;
      cp_v_r  <= (state_r == ST_COPY);

      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        full_r     <= cfg_wdata;
        cur_side_r <= cfg_eff;
      end else if ((state_r == ST_HCLEAR) && clr_done) begin
        cur_side_r <= nl;
      end else if (state_r == ST_CDRAIN) begin
        cur_side_r <= full_eff;
      end

      if (om_we && (in_val > orig_max_r)) orig_max_r <= in_val;

      if (om_we) begin
        if (idx_in_cur && (in_val > cur_max_r)) cur_max_r <= in_val;
      end else if (accept && (in_op == OP_HALVE) && (cur_side_r != '0)) begin
        cur_max_r <= '0;
      end else if (sum_v_r) begin
        if (sum_r > cur_max_r) cur_max_r <= sum_r;
      end else if (state_r == ST_CDRAIN) begin
        cur_max_r <= orig_max_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_rd_r <= '0;
      hx_r <= '0;
      hy_r <= '0;
      hz_r <= '0;
      hd_r <= '0;
      hj_r <= '0;
      clr_r    <= clr_start;
      cp_cnt_r <= '0;
      case (in_op)
        OP_LOAD:  res_status_r <= idx_in_full ? STAT_OK : STAT_RANGE;
        OP_HALVE: res_status_r <= (cur_side_r == '0) ? STAT_SIDE1 : STAT_OK;
        OP_READ:  res_status_r <= idx_in_cur ? STAT_OK : STAT_RANGE;
        default:  res_status_r <= STAT_OK;
      endcase
    end

    if (state_r == ST_READ) res_rd_r <= work_q_r;

    if (state_r == ST_HALVE) begin
      hd_r <= hd_r + 3'd1;
      if (h_block_end) begin
        hj_r <= hj_r + AW'(1);
        if (hx_r == nmask) begin
          hx_r <= '0;
          if (hy_r == nmask) begin
            hy_r <= '0;
            hz_r <= hz_r + MW'(1);
          end else begin
            hy_r <= hy_r + MW'(1);
          end
        end else begin
          hx_r <= hx_r + MW'(1);
        end
      end
    end

    // read tags line up with the registered memory output
    hrd_first_r <= (hd_r == 3'd0);
    hrd_last_r  <= h_block_end;
    hrd_j_r     <= hj_r;
    if (hrd_v_r) acc_r <= acc_in;
    if (hrd_v_r && hrd_last_r) begin
      sum_r   <= acc_in;
      sum_j_r <= hrd_j_r;
    end

    if (state_r == ST_HCLEAR) clr_r <= clr_r + AW'(1);

    if (state_r == ST_COPY) begin
      cp_cnt_r <= cp_cnt_r + AW'(1);
      cp_a_r   <= cp_cnt_r;
    end

    if (out_load) begin
      out_rd_r     <= res_rd_r;
      out_max_r    <= cur_max_r;
      out_side_r   <= cur_side_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = VALUE_W'(out_rd_r);
  assign out_ch.grid_max   = VALUE_W'(out_max_r);
  assign out_ch.side_log2  = out_side_r;
  assign out_ch.status     = out_status_r;

endmodule

// File: rtl/vgsd_checker.sv
// Checker: port-level properties of the downsampler result channel, bound to the top.
`timescale 1ns / 1ps
`include "voxel_grid_sum_downsample_macros.svh"
module vgsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [vgsd_pkg::VALUE_W-1:0]   out_read_value,
  input logic [vgsd_pkg::VALUE_W-1:0]   out_grid_max,
  input logic [vgsd_pkg::SIDE_W-1:0]    out_side_log2,
  input logic [vgsd_pkg::STATUS_W-1:0]  out_status
);
  import vgsd_pkg::*;

  `VGSD_ASSERT_NXT_ALL(a_reset_drops_valid, clk, !rst_n, !out_valid)
  `VGSD_ASSERT_NXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_grid_max) && $stable(out_side_log2) && $stable(out_status))
  // halving refused only when the grid is already a single cell
  `VGSD_ASSERT_IMP(a_side1_at_zero, clk, rst_n, out_valid && (out_status == STAT_SIDE1), out_side_log2 == '0)
  // a nonzero read word only comes from a successful read
  `VGSD_ASSERT_IMP(a_read_ok, clk, rst_n, out_valid && (out_read_value != '0), out_status == STAT_OK)

endmodule

bind voxel_grid_sum_downsample vgsd_checker u_vgsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_grid_max   (out_ch.grid_max),
  .out_side_log2  (out_ch.side_log2),
  .out_status     (out_ch.status)
);
